// ===== rtl/core/hbct_pkg.sv =====
package hbct_pkg;

   // sizing defaults
   localparam int DEF_MAX_BOXES = 128;
   localparam int DEF_TAG_COUNT = 128;

   // word layout of the tag mask
   localparam int MASK_WORD_W = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_MARGIN = 2'd2;

   // register values after reset
   localparam logic [7:0] RST_VIEW_WIDTH = 8'd128;
   localparam logic [7:0] RST_VIEW_HEIGHT = 8'd64;
   localparam logic [6:0] RST_HIT_MARGIN = 7'd64;

   // action codes
   localparam logic ACTION_CLEAR = 1'b0;
   localparam logic ACTION_BOX = 1'b1;

   // one box as it sits in a ring cell
   typedef struct packed {
      logic [6:0] tag;
      logic signed [8:0] left;
      logic signed [8:0] top;
      logic [7:0] width;
      logic [7:0] height;
   } box_type;

   // occupancy of a ring cell
   typedef enum logic [1:0] {
      CELL_FREE,
      CELL_PENDING,
      CELL_COMMITTED
   } cell_state_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic shift;
      logic drop_pending;
      logic commit;
      logic clear_all;
   } ring_ctrl_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } fsm_state_type;

endpackage

// ===== rtl/core/hbct_cell.sv =====
module hbct_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  hbct_pkg::ring_ctrl_type ctrl,
   input  hbct_pkg::box_type       nbr_box,
   input  hbct_pkg::cell_state_type nbr_state,
   output hbct_pkg::box_type       box_out,
   output hbct_pkg::cell_state_type state_out
);
   import hbct_pkg::*;

   box_type box_ff;
   cell_state_type state_ff;
   cell_state_type state_in;

   // occupancy update: clear wins, then ring shift, then group actions
   always_comb begin
      state_in = state_ff;
      priority if (ctrl.clear_all) begin
         state_in = CELL_FREE;
      end else if (ctrl.shift) begin
         state_in = nbr_state;
      end else if (ctrl.drop_pending && state_ff == CELL_PENDING) begin
         state_in = CELL_FREE;
      end else if (ctrl.commit && state_ff == CELL_PENDING) begin
         state_in = CELL_COMMITTED;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CELL_FREE;
      end else begin
         state_ff <= state_in;
      end
   end

   // box contents move with the ring
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         box_ff <= nbr_box;
      end
   end

   assign box_out = box_ff;
   assign state_out = state_ff;

endmodule

// ===== rtl/core/hbct_overlap.sv =====
module hbct_overlap (
   input  hbct_pkg::box_type stored,
   input  hbct_pkg::box_type probe,
   output logic              hit
);
   import hbct_pkg::*;

   logic signed [11:0] off_x;
   logic signed [11:0] off_y;
   logic signed [11:0] reach_x;
   logic signed [11:0] reach_y;
   logic signed [11:0] stored_w;
   logic signed [11:0] stored_h;

   // offsets of the probe corner from the stored corner
   assign off_x = {{3{probe.left[8]}}, probe.left} - {{3{stored.left[8]}}, stored.left};
   assign off_y = {{3{probe.top[8]}}, probe.top} - {{3{stored.top[8]}}, stored.top};

   // -probe.w < off  <=>  off + probe.w > 0
   assign reach_x = off_x + $signed({4'b0000, probe.width});
   assign reach_y = off_y + $signed({4'b0000, probe.height});
   assign stored_w = $signed({4'b0000, stored.width});
   assign stored_h = $signed({4'b0000, stored.height});

   // strict overlap on both axes
   assign hit = (reach_x > 12'sd0) && (off_x < stored_w) &&
                (reach_y > 12'sd0) && (off_y < stored_h);

endmodule

// ===== rtl/core/hit_box_collision_table.sv =====
// Collision table of tagged boxes held in a ring of MAX_BOXES cells. A clear word
// frees every cell. If a box word takes part (collision on, corner inside the view
// widened by the margin) the ring then turns once, and each committed box passing
// the single overlap comparator at the ring head sets its tag bit in the mask, while
// the new box drops into the first free cell it meets. A word with group_last then
// commits the pending boxes and sends (TAG_COUNT+15)/16 mask words, one per cycle
// while the output side takes them. req_ready is high only between items; the last
// mask word may still wait in the output register when the next item is taken.
// Table contents are not cleared at reset; only the cell occupancy flags are.
module hit_box_collision_table #(
   parameter int MAX_BOXES = hbct_pkg::DEF_MAX_BOXES,
   parameter int TAG_COUNT = hbct_pkg::DEF_TAG_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [6:0]                       req_box_tag,
   input  logic signed [8:0]                req_left,
   input  logic signed [8:0]                req_top,
   input  logic [7:0]                       req_box_width,
   input  logic [7:0]                       req_box_height,
   input  logic                             req_collision_on,
   input  logic                             req_store_box,
   input  logic                             req_group_first,
   input  logic                             req_group_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_mask_word_index,
   output logic [15:0]                      rsp_mask_word,
   output logic                             rsp_mask_last,
   input  logic                             csr_write,
   input  logic [hbct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbct_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hbct_pkg::*;

   localparam int WORDS = (TAG_COUNT + MASK_WORD_W - 1) / MASK_WORD_W;
   localparam int MASK_W = WORDS * MASK_WORD_W;
   localparam int CNT_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BOXES - 1);
   localparam logic [2:0] WORD_LAST = 3'(WORDS - 1);

   // configuration registers
   logic [7:0] view_width_ff;
   logic [7:0] view_height_ff;
   logic [6:0] hit_margin_ff;

   // sequencer
   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0] word_ff, word_in;
   logic stored_ff, stored_in;
   box_type query_ff, query_in;
   logic q_store_ff, q_store_in;
   logic q_last_ff, q_last_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   ring_ctrl_type ring_ctrl;
   logic store_now;
   logic load_rsp;

   // output register
   logic rsp_valid_ff;
   logic [2:0] rsp_index_ff;
   logic [15:0] rsp_word_ff;
   logic rsp_last_ff;

   // ring
   box_type cell_box [MAX_BOXES];
   cell_state_type cell_st [MAX_BOXES];
   box_type next_box [MAX_BOXES];
   cell_state_type next_st [MAX_BOXES];
   box_type tail_box;
   cell_state_type tail_st;
   logic [MAX_BOXES-1:0] cell_live;
   logic head_overlap;
   logic head_hit;

   // window check
   logic signed [9:0] new_x;
   logic signed [9:0] new_y;
   logic signed [9:0] margin_s;
   logic signed [9:0] limit_x;
   logic signed [9:0] limit_y;
   logic in_window;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= RST_VIEW_WIDTH;
         view_height_ff <= RST_VIEW_HEIGHT;
         hit_margin_ff <= RST_HIT_MARGIN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VIEW_WIDTH: view_width_ff <= csr_wdata[7:0];
            CSR_VIEW_HEIGHT: view_height_ff <= csr_wdata[7:0];
            CSR_HIT_MARGIN: hit_margin_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // corner inside the widened view
   assign new_x = {req_left[8], req_left};
   assign new_y = {req_top[8], req_top};
   assign margin_s = {3'b000, hit_margin_ff};
   assign limit_x = $signed({2'b00, view_width_ff}) + margin_s;
   assign limit_y = $signed({2'b00, view_height_ff}) + margin_s;
   assign in_window = (new_x >= -margin_s) && (new_x < limit_x) &&
                      (new_y >= -margin_s) && (new_y < limit_y);

   // ring of cells, head is cell 0, tail is the last cell
   assign tail_box = store_now ? query_ff : cell_box[0];
   assign tail_st = store_now ? CELL_PENDING : cell_st[0];

   for (genvar k = 0; k < MAX_BOXES; k++) begin : g_ring
      if (k == MAX_BOXES - 1) begin : g_tail
         assign next_box[k] = tail_box;
         assign next_st[k] = tail_st;
      end else begin : g_mid
         assign next_box[k] = cell_box[k+1];
         assign next_st[k] = cell_st[k+1];
      end

      hbct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ring_ctrl),
         .nbr_box   (next_box[k]),
         .nbr_state (next_st[k]),
         .box_out   (cell_box[k]),
         .state_out (cell_st[k])
      );

      assign cell_live[k] = (cell_st[k] != CELL_FREE);
   end

   // comparator at the ring head
   hbct_overlap u_overlap (
      .stored (cell_box[0]),
      .probe  (query_ff),
      .hit    (head_overlap)
   );

   assign head_hit = (cell_st[0] == CELL_COMMITTED) && head_overlap;

   // sequencer next state and controls
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      word_in = word_ff;
      stored_in = stored_ff;
      query_in = query_ff;
      q_store_in = q_store_ff;
      q_last_in = q_last_ff;
      mask_in = mask_ff;
      ring_ctrl = '0;
      req_ready = 1'b0;
      store_now = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACTION_CLEAR) begin
                  ring_ctrl.clear_all = 1'b1;
               end else begin
                  query_in.tag = req_box_tag;
                  query_in.left = req_left;
                  query_in.top = req_top;
                  query_in.width = req_box_width;
                  query_in.height = req_box_height;
                  q_store_in = req_store_box;
                  q_last_in = req_group_last;
                  if (req_group_first) begin
                     mask_in = '0;
                     ring_ctrl.drop_pending = 1'b1;
                  end
                  if (req_collision_on && in_window) begin
                     state_in = ST_SCAN;
                     cnt_in = '0;
                     stored_in = 1'b0;
                  end else if (req_group_last) begin
                     state_in = ST_EMIT;
                     word_in = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            ring_ctrl.shift = 1'b1;
            // tag decode of a hit at the head
            for (int b = 0; b < MASK_W; b++) begin
               if (b < TAG_COUNT && head_hit && cell_st[0] == CELL_COMMITTED &&
                   cell_box[0].tag == 7'(b)) begin
                  mask_in[b] = 1'b1;
               end
            end
            // new box takes the first free cell it meets
            if (cell_st[0] == CELL_FREE && q_store_ff && !stored_ff) begin
               store_now = 1'b1;
               stored_in = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (q_last_ff) begin
                  state_in = ST_EMIT;
                  word_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            ring_ctrl.commit = 1'b1;
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               if (word_ff == WORD_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         word_ff <= '0;
         stored_ff <= 1'b0;
         mask_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         word_ff <= word_in;
         stored_ff <= stored_in;
         mask_ff <= mask_in;
      end
   end

   // current box under test
   always_ff @(posedge clock) begin
      query_ff <= query_in;
      q_store_ff <= q_store_in;
      q_last_ff <= q_last_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_index_ff <= word_ff;
         rsp_word_ff <= mask_ff[{word_ff, 4'b0000} +: MASK_WORD_W];
         rsp_last_ff <= (word_ff == WORD_LAST);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mask_word_index = rsp_index_ff;
   assign rsp_mask_word = rsp_word_ff;
   assign rsp_mask_last = rsp_last_ff;

   // no tag at or above the tag count ever reaches the mask
   a_mask_tags: assert property (@(posedge clock) disable iff (reset)
      (MASK_W'(mask_ff >> TAG_COUNT) == '0))
      else $error("mask bit set beyond tag count");

   // a clear word leaves every cell free
   a_clear_frees: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACTION_CLEAR) |=> (cell_live == '0))
      else $error("cell still occupied after clear");

   // a scan always leaves after a full ring turn
   a_scan_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in != ST_SCAN) |-> (cnt_ff == CNT_LAST))
      else $error("scan left before full ring turn");

endmodule

// ===== sim/hbct_checker.sv =====
`timescale 1ns / 100ps

module hbct_checker #(
   parameter int MAX_BOXES = hbct_pkg::DEF_MAX_BOXES,
   parameter int TAG_COUNT = hbct_pkg::DEF_TAG_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_action,
   input  logic [6:0]                       req_box_tag,
   input  logic signed [8:0]                req_left,
   input  logic signed [8:0]                req_top,
   input  logic [7:0]                       req_box_width,
   input  logic [7:0]                       req_box_height,
   input  logic                             req_collision_on,
   input  logic                             req_store_box,
   input  logic                             req_group_first,
   input  logic                             req_group_last,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_mask_word_index,
   input  logic [15:0]                      rsp_mask_word,
   input  logic                             rsp_mask_last,
   input  logic                             csr_write,
   input  logic [hbct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hbct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               words_pending,
   output int                               words_checked
);
   import hbct_pkg::*;

   localparam int MASK_WORDS = (TAG_COUNT + 15) / 16;

   typedef struct {
      logic [2:0]  index;
      logic [15:0] bits;
      logic        last;
   } mask_word_type;

   // predicted table, counts, mask and view settings
   box_type       stored_boxes [MAX_BOXES];
   int            committed_boxes;
   int            pending_boxes;
   logic [15:0]   hit_mask [8];
   int            view_w;
   int            view_h;
   int            margin;
   mask_word_type mask_words_due [$];

   function automatic int sext9(logic [8:0] v);
      return {{23{v[8]}}, v};
   endfunction

   // strict overlap of a new box against a held one
   function automatic bit boxes_overlap(box_type held, box_type probe);
      int dx;
      int dy;
      dx = sext9(probe.left) - sext9(held.left);
      dy = sext9(probe.top) - sext9(held.top);
      return (-int'(probe.width) < dx) && (dx < int'(held.width)) &&
             (-int'(probe.height) < dy) && (dy < int'(held.height));
   endfunction

   // corner inside the view widened by the margin
   function automatic bit in_window(box_type probe);
      int lx;
      int ty;
      lx = sext9(probe.left);
      ty = sext9(probe.top);
      return (lx >= -margin) && (lx < view_w + margin) &&
             (ty >= -margin) && (ty < view_h + margin);
   endfunction

   task automatic reset_model();
      int k;
      committed_boxes = 0;
      pending_boxes = 0;
      for (k = 0; k < 8; k++) hit_mask[k] = '0;
      view_w = int'(RST_VIEW_WIDTH);
      view_h = int'(RST_VIEW_HEIGHT);
      margin = int'(RST_HIT_MARGIN);
      mask_words_due.delete();
      mismatch_count = 0;
      words_checked = 0;
   endtask

   task automatic write_register();
      case (csr_index)
         CSR_VIEW_WIDTH:  view_w = int'(csr_wdata);
         CSR_VIEW_HEIGHT: view_h = int'(csr_wdata);
         CSR_HIT_MARGIN:  margin = int'(csr_wdata[6:0]);
         default: ;
      endcase
   endtask

   // one accepted request word: clear, or test, store and maybe emit
   task automatic take_request();
      box_type probe;
      int      k;
      if (req_action == ACTION_CLEAR) begin
         committed_boxes = 0;
         pending_boxes = 0;
         return;
      end
      probe = '{tag: req_box_tag, left: req_left, top: req_top,
                width: req_box_width, height: req_box_height};
      if (req_group_first) begin
         for (k = 0; k < 8; k++) hit_mask[k] = '0;
         pending_boxes = committed_boxes;
      end
      if (req_collision_on && in_window(probe)) begin
         for (k = 0; k < committed_boxes && k < MAX_BOXES; k++) begin
            if (boxes_overlap(stored_boxes[k], probe) && stored_boxes[k].tag < TAG_COUNT)
               hit_mask[stored_boxes[k].tag[6:4]][stored_boxes[k].tag[3:0]] = 1'b1;
         end
         if (req_store_box && pending_boxes < MAX_BOXES) begin
            stored_boxes[pending_boxes] = probe;
            pending_boxes++;
         end
      end
      if (req_group_last) begin
         committed_boxes = pending_boxes;
         for (k = 0; k < MASK_WORDS && k < 8; k++)
            mask_words_due.push_back('{index: k[2:0], bits: hit_mask[k],
                                       last: (k + 1 == MASK_WORDS)});
      end
   endtask

   // compare one mask word with the oldest prediction
   task automatic check_mask_word();
      mask_word_type due;
      if (mask_words_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected mask word: index %0d word %h last %b",
                     rsp_mask_word_index, rsp_mask_word, rsp_mask_last);
         return;
      end
      due = mask_words_due.pop_front();
      words_checked++;
      if (rsp_mask_word_index !== due.index || rsp_mask_word !== due.bits ||
          rsp_mask_last !== due.last) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mask word %0d: expected index %0d word %h last %b, got %0d %h %b",
                     words_checked, due.index, due.bits, due.last,
                     rsp_mask_word_index, rsp_mask_word, rsp_mask_last);
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_valid && rsp_ready) check_mask_word();
         if (csr_write) write_register();
         if (req_valid && req_ready) take_request();
      end
      words_pending <= mask_words_due.size();
   end

endmodule

// ===== sim/tb_hit_box_collision_table.sv =====
`timescale 1ns / 100ps

module tb_hit_box_collision_table;
   import hbct_pkg::*;

   localparam int DRAIN_CYCLES = 2 * DEF_MAX_BOXES + 40;
   localparam int LONG_STALL = 600;
   localparam int TIMEOUT_NS = 5_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_action = ACTION_CLEAR;
   logic [6:0]             req_box_tag = '0;
   logic signed [8:0]      req_left = '0;
   logic signed [8:0]      req_top = '0;
   logic [7:0]             req_box_width = '0;
   logic [7:0]             req_box_height = '0;
   logic                   req_collision_on = 1'b0;
   logic                   req_store_box = 1'b0;
   logic                   req_group_first = 1'b0;
   logic                   req_group_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_mask_word_index;
   logic [15:0]            rsp_mask_word;
   logic                   rsp_mask_last;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_VIEW_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int words_pending;
   int words_checked;

   // stimulus bookkeeping and the view settings last written
   int view_w_cfg = int'(RST_VIEW_WIDTH);
   int view_h_cfg = int'(RST_VIEW_HEIGHT);
   int margin_cfg = int'(RST_HIT_MARGIN);
   int words_sent = 0;
   int clears_sent = 0;
   int groups_closed = 0;
   int settings_used = 0;
   bit quiet_tail = 1'b0;
   bit hold_output = 1'b0;
   bit hold_taken = 1'b0;
   int stall_count;

   hit_box_collision_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_box_tag         (req_box_tag),
      .req_left            (req_left),
      .req_top             (req_top),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_collision_on    (req_collision_on),
      .req_store_box       (req_store_box),
      .req_group_first     (req_group_first),
      .req_group_last      (req_group_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mask_word_index (rsp_mask_word_index),
      .rsp_mask_word       (rsp_mask_word),
      .rsp_mask_last       (rsp_mask_last),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   hbct_checker mask_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_box_tag         (req_box_tag),
      .req_left            (req_left),
      .req_top             (req_top),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_collision_on    (req_collision_on),
      .req_store_box       (req_store_box),
      .req_group_first     (req_group_first),
      .req_group_last      (req_group_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mask_word_index (rsp_mask_word_index),
      .rsp_mask_word       (rsp_mask_word),
      .rsp_mask_last       (rsp_mask_last),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .words_pending       (words_pending),
      .words_checked       (words_checked)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // output side: random ready bursts, one long hold-off on request
   always begin
      @(posedge clock);
      if (hold_output && !hold_taken) begin
         hold_taken = 1'b1;
         rsp_ready <= 1'b0;
         for (stall_count = 0; stall_count < LONG_STALL; stall_count++) @(posedge clock);
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end else begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // offer one word and hold it until taken, then maybe go idle
   task automatic send_word(bit action, int tag, int left, int top, int wid, int hgt,
                            bit on, bit store, bit first_flag, bit last_flag);
      req_valid <= 1'b1;
      req_action <= action;
      req_box_tag <= tag[6:0];
      req_left <= left[8:0];
      req_top <= top[8:0];
      req_box_width <= wid[7:0];
      req_box_height <= hgt[7:0];
      req_collision_on <= on;
      req_store_box <= store;
      req_group_first <= first_flag;
      req_group_last <= last_flag;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (action == ACTION_CLEAR) clears_sent++;
      else if (last_flag) groups_closed++;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // stop sending until every predicted word is back and the scan has ended
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_view(int wid, int hgt, logic [7:0] margin_raw);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= CSR_VIEW_WIDTH;
      csr_wdata <= wid[7:0];
      @(posedge clock);
      csr_index <= CSR_VIEW_HEIGHT;
      csr_wdata <= hgt[7:0];
      @(posedge clock);
      csr_index <= CSR_HIT_MARGIN;
      csr_wdata <= margin_raw;
      @(posedge clock);
      csr_write <= 1'b0;
      view_w_cfg = wid;
      view_h_cfg = hgt;
      margin_cfg = int'(margin_raw[6:0]);
      settings_used++;
   endtask

   function automatic int coord_in_view(int span);
      int lo;
      int hi;
      lo = -margin_cfg;
      hi = span + margin_cfg - 1;
      if (hi > 255) hi = 255;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // mix of thin, medium, any and widest extents
   function automatic int pick_extent();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8);
         1: return $urandom_range(1, 40);
         2: return $urandom_range(0, 255);
         default: return 255;
      endcase
   endfunction

   task automatic send_random_box(bit first_flag, bit last_flag, bit keep_all);
      send_word(ACTION_BOX, $urandom_range(0, 127), coord_in_view(view_w_cfg),
                coord_in_view(view_h_cfg), pick_extent(), pick_extent(),
                keep_all || $urandom_range(0, 19) != 0,
                keep_all || $urandom_range(0, 4) != 0, first_flag, last_flag);
   endtask

   // random field values with coordinates -128..255, a third of them clears
   task automatic send_noise();
      send_word($urandom_range(0, 2) != 0, $urandom_range(0, 127),
                int'($urandom_range(0, 383)) - 128, int'($urandom_range(0, 383)) - 128,
                $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // a frame: clear, then groups of boxes, some with missing group flags
   task automatic run_frame(int n_boxes, bit strict);
      int sent;
      int grp;
      int k;
      send_word(ACTION_CLEAR, $urandom_range(0, 127), 0, 0, 0, 0, 1'b0, 1'b0,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < n_boxes) begin
         grp = $urandom_range(1, 6);
         if (grp > n_boxes - sent) grp = n_boxes - sent;
         for (k = 0; k < grp; k++) begin
            if (!strict && $urandom_range(0, 7) == 0)
               send_noise();
            else
               send_random_box(k == 0 && (strict || $urandom_range(0, 9) != 0),
                               k == grp - 1 && (strict || $urandom_range(0, 9) != 0),
                               strict);
         end
         sent += grp;
      end
   endtask

   initial begin
      int p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset view (window -64..191 by -64..127)
      send_word(ACTION_CLEAR, 127, 255, 255, 255, 255, 1, 1, 1, 1);
      send_word(ACTION_BOX, 0, 0, 0, 10, 10, 1, 1, 1, 0);
      send_word(ACTION_BOX, 127, 5, 5, 255, 255, 1, 1, 0, 1);
      // lands inside both earlier boxes
      send_word(ACTION_BOX, 5, 9, 9, 1, 1, 1, 1, 1, 1);
      // edges only touch, strict test gives no hit, not stored
      send_word(ACTION_BOX, 20, 10, 0, 5, 5, 1, 0, 1, 1);
      send_word(ACTION_BOX, 33, 0, 0, 0, 0, 1, 1, 1, 1);
      // window corners, just inside and just outside
      send_word(ACTION_BOX, 64, -64, 127, 255, 255, 1, 1, 1, 1);
      send_word(ACTION_BOX, 65, -65, 0, 255, 255, 1, 1, 1, 1);
      send_word(ACTION_BOX, 66, 191, -64, 4, 4, 1, 1, 1, 1);
      send_word(ACTION_BOX, 67, 192, 0, 4, 4, 1, 1, 1, 1);
      send_word(ACTION_BOX, 68, 0, 128, 4, 4, 1, 1, 1, 1);
      send_word(ACTION_BOX, 69, -128, 255, 255, 255, 1, 1, 1, 1);
      send_word(ACTION_BOX, 70, 255, -128, 255, 255, 1, 1, 1, 1);
      // collision off still closes the group
      send_word(ACTION_BOX, 71, 0, 0, 255, 255, 0, 1, 1, 1);
      // group with no first flag carries the mask over
      send_word(ACTION_BOX, 1, 2, 2, 3, 3, 1, 1, 0, 0);
      send_word(ACTION_BOX, 2, 3, 3, 3, 3, 1, 1, 0, 1);
      // clear ignores its group flags
      send_word(ACTION_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 1);
      send_word(ACTION_BOX, 3, 0, 0, 255, 255, 1, 1, 1, 1);
      send_word(ACTION_BOX, 4, 1, 1, 2, 2, 1, 1, 1, 1);

      // widest view, then fill the table past its size
      set_view(255, 255, 8'hFF);
      run_frame(150, 1'b1);

      // narrowest view
      set_view(1, 1, 8'h00);
      run_frame(25, 1'b0);

      // small view, then a long output stall while boxes keep coming
      set_view(40, 30, 8'd10);
      run_frame(25, 1'b0);
      hold_output <= 1'b1;
      for (p = 0; p < 6; p++) send_random_box(1'b1, 1'b1, 1'b1);

      for (p = 0; p < 5; p++) begin
         set_view($urandom_range(1, 255), $urandom_range(1, 255),
                  8'($urandom_range(0, 127)));
         run_frame(25, 1'b0);
      end

      // back to the reset view with both sides running flat out
      set_view(int'(RST_VIEW_WIDTH), int'(RST_VIEW_HEIGHT), {1'b0, RST_HIT_MARGIN});
      quiet_tail = 1'b1;
      run_frame(25, 1'b0);

      drain_results();
      $display("Sent %0d words: %0d clears, %0d group ends, %0d view settings",
               words_sent, clears_sent, groups_closed, settings_used);
      $display("Compared %0d mask words over a full table, window edges and a long stall",
               words_checked);
      if (mismatch_count == 0 && words_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d mask words outstanding", words_pending);
      $display("Mismatches found");
      $finish;
   end

endmodule
